// ===== design/fieq_pkg.sv =====
// shared types and constants for the filtered interrupt event queue
`timescale 1ns / 1ps
`default_nettype none

package fieq_pkg;

    // request codes
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_TAKE  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ENABLE_MASK     = 2'd0;
    localparam logic [1:0] CFG_LOW_ID          = 2'd1;
    localparam logic [1:0] CFG_HIGH_ID         = 2'd2;
    localparam logic [1:0] CFG_HANDLERS_ACTIVE = 2'd3;

    // number of interrupt sources with an enable bit
    localparam int unsigned SOURCE_COUNT = 64;

    // register widths
    localparam int unsigned MASK_W = 64;
    localparam int unsigned ID_W   = 8;
    localparam int unsigned RES_W  = 16;
    localparam int unsigned SEL_W  = 6;

    // reset value of the upper id window limit
    localparam logic [ID_W-1:0] HIGH_ID_RESET = 8'd63;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_RANGE  = 2'd1,
        STATUS_DENIED = 2'd2,
        STATUS_FULL   = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic {
        S_IDLE,
        S_TAKE
    } state_t;

    // true when the source has its enable bit set
    function automatic logic source_enabled(input logic [ID_W-1:0] id,
                                            input logic [MASK_W-1:0] mask);
        logic in_count;
        in_count = ({24'd0, id} < SOURCE_COUNT) && (id < 8'd64);
        return in_count && mask[id[SEL_W-1:0]];
    endfunction

endpackage

`default_nettype wire

// ===== design/filtered_interrupt_event_queue_top.sv =====
// Results: an add, a clear, or a take on an empty queue gives its result in the cycle after
// acceptance; a take that removes an entry goes through the registered ram read first.
// Throughput: one item per cycle while the result channel is not stalled; a take that
// removes an entry holds off new requests during the registered read of the slot ram.
// Reset: queue empty, indexes and fill count zero, configuration registers at their reset
// values; the slot ram is not cleared, as occupancy follows from the fill count.
`timescale 1ns / 1ps
`default_nettype none

module filtered_interrupt_event_queue_top
    import fieq_pkg::*;
#(
    parameter int unsigned QUEUE_LOG_DEPTH = 5
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [MASK_W-1:0] cfg_wdata,
    // request channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_req_type,
    input  wire logic [ID_W-1:0]   s_source_id,
    input  wire logic [RES_W-1:0]  s_resource_number,
    // result channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_status,
    output logic                   m_took_valid,
    output logic [ID_W-1:0]        m_out_id,
    output logic [RES_W-1:0]       m_out_resource,
    output logic                   m_deliver,
    output logic                   m_more_pending
);

    localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_LOG_DEPTH;
    localparam int unsigned CNT_W       = QUEUE_LOG_DEPTH + 1;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
    localparam int unsigned SLOT_W      = ID_W + RES_W;

    // configuration registers
    logic [MASK_W-1:0] enable_mask_reg;
    logic [ID_W-1:0]   low_id_reg;
    logic [ID_W-1:0]   high_id_reg;
    logic              handlers_active_reg;

    // queue control
    state_t                     state_reg, state_next;
    logic [QUEUE_LOG_DEPTH-1:0] read_index_reg, read_index_next;
    logic [QUEUE_LOG_DEPTH-1:0] write_index_reg, write_index_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       more_reg, more_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic              out_took_reg, out_took_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic [RES_W-1:0]  out_res_reg, out_res_next;
    logic              out_deliver_reg, out_deliver_next;
    logic              out_more_reg, out_more_next;

    // slot ram
    logic              ram_wr_en;
    logic [SLOT_W-1:0] ram_rd_data;
    logic [ID_W-1:0]   rd_id;
    logic [RES_W-1:0]  rd_res;

    logic accept;
    logic in_window;
    logic allowed;

    fieq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (write_index_reg),
        .wr_data ({s_source_id, s_resource_number}),
        .rd_addr (read_index_reg),
        .rd_data (ram_rd_data)
    );

    assign rd_id  = ram_rd_data[SLOT_W-1:RES_W];
    assign rd_res = ram_rd_data[RES_W-1:0];

    // handshake
    assign s_ready = (state_reg == S_IDLE) && (!out_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // add filters
    assign in_window = (s_source_id >= low_id_reg) && (s_source_id <= high_id_reg);
    assign allowed   = handlers_active_reg && source_enabled(s_source_id, enable_mask_reg);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_mask_reg     <= '0;
            low_id_reg          <= '0;
            high_id_reg         <= HIGH_ID_RESET;
            handlers_active_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ENABLE_MASK:     enable_mask_reg     <= cfg_wdata;
                CFG_LOW_ID:          low_id_reg          <= cfg_wdata[ID_W-1:0];
                CFG_HIGH_ID:         high_id_reg         <= cfg_wdata[ID_W-1:0];
                CFG_HANDLERS_ACTIVE: handlers_active_reg <= cfg_wdata[0];
            endcase
        end
    end

    // next state, queue updates and result
    always_comb begin
        state_next       = state_reg;
        read_index_next  = read_index_reg;
        write_index_next = write_index_reg;
        count_next       = count_reg;
        more_next        = more_reg;
        ram_wr_en        = 1'b0;

        out_valid_next   = out_valid_reg && !m_ready;
        out_status_next  = out_status_reg;
        out_took_next    = out_took_reg;
        out_id_next      = out_id_reg;
        out_res_next     = out_res_reg;
        out_deliver_next = out_deliver_reg;
        out_more_next    = out_more_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    out_status_next  = STATUS_OK;
                    out_took_next    = 1'b0;
                    out_id_next      = '0;
                    out_res_next     = '0;
                    out_deliver_next = 1'b0;
                    out_more_next    = 1'b0;
                    out_valid_next   = 1'b1;
                    case (s_req_type)
                        REQ_ADD: begin
                            if (!in_window) begin
                                out_status_next = STATUS_RANGE;
                            end else if (!allowed) begin
                                out_status_next = STATUS_DENIED;
                            end else if (count_reg == FULL_COUNT) begin
                                out_status_next = STATUS_FULL;
                            end else begin
                                ram_wr_en        = 1'b1;
                                write_index_next = write_index_reg + 1'b1;
                                count_next       = count_reg + 1'b1;
                            end
                        end
                        REQ_TAKE: begin
                            // an entry waits: read it from the ram next cycle
                            if (count_reg != '0) begin
                                out_valid_next  = 1'b0;
                                read_index_next = read_index_reg + 1'b1;
                                count_next      = count_reg - 1'b1;
                                more_next       = (count_reg != CNT_W'(1));
                                state_next      = S_TAKE;
                            end
                        end
                        REQ_CLEAR: begin
                            read_index_next  = '0;
                            write_index_next = '0;
                            count_next       = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TAKE: begin
                out_valid_next   = 1'b1;
                out_status_next  = STATUS_OK;
                out_took_next    = 1'b1;
                out_id_next      = rd_id;
                out_res_next     = rd_res;
                out_deliver_next = source_enabled(rd_id, enable_mask_reg);
                out_more_next    = more_reg;
                state_next       = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            read_index_reg  <= '0;
            write_index_reg <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            read_index_reg  <= read_index_next;
            write_index_reg <= write_index_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        more_reg        <= more_next;
        out_status_reg  <= out_status_next;
        out_took_reg    <= out_took_next;
        out_id_reg      <= out_id_next;
        out_res_reg     <= out_res_next;
        out_deliver_reg <= out_deliver_next;
        out_more_reg    <= out_more_next;
    end

    // result outputs
    assign m_valid        = out_valid_reg;
    assign m_status       = out_status_reg;
    assign m_took_valid   = out_took_reg;
    assign m_out_id       = out_id_reg;
    assign m_out_resource = out_res_reg;
    assign m_deliver      = out_deliver_reg;
    assign m_more_pending = out_more_reg;

endmodule

`default_nettype wire

// ===== design/fieq_ram.sv =====
// generic simple dual-port ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module fieq_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire
